// ===== hw/rtl/fpd_pkg.sv =====
// shared types, sizes and phrase tables for the folded phrase detector
// no dependencies; used by the interfaces and imported by every module
package fpd_pkg;

  localparam int BYTE_W          = 8;
  localparam int CHAR_W          = 7;
  localparam int EXACT_PHRASES   = 14;
  localparam int OPENING_PHRASES = 4;
  localparam int ENDING_PHRASES  = 2;
  localparam int TAIL_DEPTH      = 14;
  localparam int COUNT_LIMIT     = 63;
  localparam int LEN_W           = 6;
  localparam int CNT_W           = $clog2(COUNT_LIMIT + 1);
  localparam int PHRASE_CHARS    = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  typedef logic [BYTE_W*PHRASE_CHARS-1:0] phrase_t;
  typedef logic [CHAR_W-1:0]              char_t;
  typedef logic [CNT_W-1:0]               count_t;

  // one folded step handed from front to back
  typedef struct packed {
    logic  push;
    char_t ch;
    logic  last;
  } entry_t;

  localparam phrase_t EXACT_ROM [EXACT_PHRASES] = '{
    phrase_t'("altyazimk"),
    phrase_t'({"altyazimk", "com"}),
    phrase_t'("altyaziauthor"),
    phrase_t'("aboneolmayiunutmayin"),
    phrase_t'("kanalimaaboneolmayiunutmayin"),
    phrase_t'("videoyubegendiyseniz"),
    phrase_t'("bubolumunbetimlemesi"),
    phrase_t'({"subtitlesbythe", "amara", "org", "community"}),
    phrase_t'({"subtitlesby", "amara", "org"}),
    phrase_t'({"amara", "org"}),
    phrase_t'("thanksforwatching"),
    phrase_t'("thankyouforwatching"),
    phrase_t'("pleasesubscribe"),
    phrase_t'("subscribetomychannel")
  };
  localparam int EXACT_LEN [EXACT_PHRASES] =
    '{9, 12, 13, 20, 28, 20, 20, 31, 19, 8, 17, 19, 15, 20};

  localparam phrase_t OPENING_ROM [OPENING_PHRASES] = '{
    phrase_t'("budizininbetimlemesi"),
    phrase_t'("bufilminbetimlemesi"),
    phrase_t'("buprograminbetimlemesi"),
    phrase_t'("bubolumunbetimlemesi")
  };
  localparam int OPENING_LEN [OPENING_PHRASES] = '{20, 19, 22, 20};

  localparam phrase_t ENDING_ROM [ENDING_PHRASES] = '{
    phrase_t'("yaptirilmistir"),
    phrase_t'("yapilmistir")
  };
  localparam int ENDING_LEN [ENDING_PHRASES] = '{14, 11};

  // character at position pos of a right-justified phrase, zero past its end
  function automatic char_t rom_char(phrase_t s, int len, count_t pos);
    char_t c;
    c = '0;
    if (int'(pos) < len) begin
      c = s[BYTE_W*(len-1-int'(pos)) +: CHAR_W];
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/fpd_if.sv =====
// valid/ready channels for text bytes in and verdict words out
// depends on fpd_pkg for field widths
interface fpd_in_if;
  logic                        valid;
  logic                        ready;
  logic [fpd_pkg::BYTE_W-1:0]  text_byte;
  logic                        line_end;
  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface fpd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        phrase_found;
  logic [fpd_pkg::LEN_W-1:0]   folded_length;
  modport source (output valid, output phrase_found, output folded_length, input ready);
  modport sink   (input valid, input phrase_found, input folded_length, output ready);
endinterface

// ===== hw/rtl/fpd_front.sv =====
// front end: utf-8 decode and case fold, one byte per cycle
// unless q_full; uses fpd_pkg, fpd_in_if; feeds fpd_queue
module fpd_front (
  input  logic            clk,
  input  logic            rst_n,
  fpd_in_if.sink          in_word,
  input  logic            q_full,
  output logic            q_wr,
  output fpd_pkg::entry_t q_data
);
  import fpd_pkg::*;

  localparam logic [15:0] PAIR_C_LO = 16'hC3A7;
  localparam logic [15:0] PAIR_C_UP = 16'hC387;
  localparam logic [15:0] PAIR_G_LO = 16'hC49F;
  localparam logic [15:0] PAIR_G_UP = 16'hC49E;
  localparam logic [15:0] PAIR_I_LO = 16'hC4B1;
  localparam logic [15:0] PAIR_I_UP = 16'hC4B0;
  localparam logic [15:0] PAIR_O_LO = 16'hC3B6;
  localparam logic [15:0] PAIR_O_UP = 16'hC396;
  localparam logic [15:0] PAIR_S_LO = 16'hC59F;
  localparam logic [15:0] PAIR_S_UP = 16'hC59E;
  localparam logic [15:0] PAIR_U_LO = 16'hC3BC;
  localparam logic [15:0] PAIR_U_UP = 16'hC39C;
  localparam logic [1:0]  CONT_TAG  = 2'b10;

  logic              lead_pending_r, lead_pending_nxt;
  logic [BYTE_W-1:0] lead_value_r, lead_value_nxt;
  logic              skipping_r, skipping_nxt;
  logic              accept;
  logic              cont;
  char_t             mapped;
  entry_t            entry;
  logic [BYTE_W-1:0] b;

  function automatic char_t turkish_map(logic [15:0] pair);
    char_t c;
    unique case (pair)
      PAIR_C_LO, PAIR_C_UP: c = CHAR_W'("c");
      PAIR_G_LO, PAIR_G_UP: c = CHAR_W'("g");
      PAIR_I_LO, PAIR_I_UP: c = CHAR_W'("i");
      PAIR_O_LO, PAIR_O_UP: c = CHAR_W'("o");
      PAIR_S_LO, PAIR_S_UP: c = CHAR_W'("s");
      PAIR_U_LO, PAIR_U_UP: c = CHAR_W'("u");
      default:              c = '0;
    endcase
    return c;
  endfunction

  assign b          = in_word.text_byte;
  assign accept     = in_word.valid && in_word.ready;
  assign in_word.ready = !q_full;
  assign cont       = (b[7:6] == CONT_TAG);
  assign mapped     = turkish_map({lead_value_r, b});

  always_comb begin
    logic fresh;
    fresh            = 1'b0;
    lead_pending_nxt = lead_pending_r;
    lead_value_nxt   = lead_value_r;
    skipping_nxt     = skipping_r;
    entry.push       = 1'b0;
    entry.ch         = '0;
    entry.last       = in_word.line_end;
    if (lead_pending_r) begin
      lead_pending_nxt = 1'b0;
      lead_value_nxt   = '0;
      if (mapped != '0) begin
        entry.push = 1'b1;
        entry.ch   = mapped;
      end else if (cont) begin
        skipping_nxt = 1'b1;
      end else begin
        fresh = 1'b1;
      end
    end else if (skipping_r) begin
      if (!cont) begin
        skipping_nxt = 1'b0;
        fresh        = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end
    if (fresh) begin
      if (!b[7]) begin
        if (b >= "A" && b <= "Z") begin
          entry.push = 1'b1;
          entry.ch   = CHAR_W'(b + 8'd32);
        end else if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) begin
          entry.push = 1'b1;
          entry.ch   = b[CHAR_W-1:0];
        end
      end else begin
        lead_pending_nxt = 1'b1;
        lead_value_nxt   = b;
      end
    end
    // a pending lead byte at line end is simply dropped
    if (in_word.line_end) begin
      lead_pending_nxt = 1'b0;
      lead_value_nxt   = '0;
      skipping_nxt     = 1'b0;
    end
  end

  assign q_wr   = accept && (entry.push || entry.last);
  assign q_data = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      lead_value_r   <= '0;
      skipping_r     <= 1'b0;
    end else if (accept) begin
      lead_pending_r <= lead_pending_nxt;
      lead_value_r   <= lead_value_nxt;
      skipping_r     <= skipping_nxt;
    end
  end

endmodule

// ===== hw/rtl/fpd_queue.sv =====
// short fifo of folded steps between front and back
// depends on fpd_pkg
module fpd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  fpd_pkg::entry_t wr_data,
  output logic            full,
  output logic            rd_valid,
  output fpd_pkg::entry_t rd_data,
  input  logic            rd_en
);
  import fpd_pkg::*;

  entry_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) n = '0;
    else                               n = p + 1'b1;
    return n;
  endfunction

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_rd) rd_ptr_r <= ptr_inc(rd_ptr_r);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/fpd_back.sv =====
// back end: phrase matching, key count, tail window and verdict register
// depends on fpd_pkg and fpd_out_if; drains fpd_queue
module fpd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  fpd_pkg::entry_t q_data,
  output logic            q_rd,
  fpd_out_if.source       out_word
);
  import fpd_pkg::*;

  logic [EXACT_PHRASES-1:0]   exact_alive_r, exact_alive_nxt, exact_upd;
  logic [OPENING_PHRASES-1:0] open_alive_r, open_alive_nxt, open_upd;
  count_t                     key_count_r, key_count_nxt, count_upd;
  char_t                      tail_r [TAIL_DEPTH];
  char_t                      tail_nxt [TAIL_DEPTH];
  char_t                      tail_upd [TAIL_DEPTH];
  logic                       out_valid_r;
  logic                       found_r;
  logic [LEN_W-1:0]           length_r;
  logic                       out_free, pop, found;
  logic [ENDING_PHRASES-1:0]  end_hit;

  assign out_free = !out_valid_r || out_word.ready;
  assign q_rd     = q_valid && (!q_data.last || out_free);
  assign pop      = q_rd;

  always_comb begin
    exact_upd = exact_alive_r;
    open_upd  = open_alive_r;
    count_upd = key_count_r;
    tail_upd  = tail_r;
    if (pop && q_data.push) begin
      for (int k = 0; k < EXACT_PHRASES; k++) begin
        if (rom_char(EXACT_ROM[k], EXACT_LEN[k], key_count_r) != q_data.ch) begin
          exact_upd[k] = 1'b0;
        end
      end
      for (int k = 0; k < OPENING_PHRASES; k++) begin
        if (int'(key_count_r) < OPENING_LEN[k] &&
            rom_char(OPENING_ROM[k], OPENING_LEN[k], key_count_r) != q_data.ch) begin
          open_upd[k] = 1'b0;
        end
      end
      for (int i = TAIL_DEPTH - 1; i > 0; i--) begin
        tail_upd[i] = tail_r[i-1];
      end
      tail_upd[0] = q_data.ch;
      if (key_count_r != CNT_W'(COUNT_LIMIT)) begin
        count_upd = key_count_r + 1'b1;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < ENDING_PHRASES; j++) begin
      end_hit[j] = (ENDING_LEN[j] <= TAIL_DEPTH);
      for (int i = 0; i < ENDING_LEN[j] && i < TAIL_DEPTH; i++) begin
        if (tail_upd[i] !=
            rom_char(ENDING_ROM[j], ENDING_LEN[j], CNT_W'(ENDING_LEN[j] - 1 - i))) begin
          end_hit[j] = 1'b0;
        end
      end
    end
    found = 1'b0;
    for (int k = 0; k < EXACT_PHRASES; k++) begin
      if (exact_upd[k] && int'(count_upd) == EXACT_LEN[k]) found = 1'b1;
    end
    for (int k = 0; k < OPENING_PHRASES; k++) begin
      for (int j = 0; j < ENDING_PHRASES; j++) begin
        if (open_upd[k] && end_hit[j] &&
            int'(count_upd) >= OPENING_LEN[k] + ENDING_LEN[j]) begin
          found = 1'b1;
        end
      end
    end
    if (count_upd == '0) found = 1'b0;
  end

  always_comb begin
    exact_alive_nxt = exact_upd;
    open_alive_nxt  = open_upd;
    key_count_nxt   = count_upd;
    tail_nxt        = tail_upd;
    if (pop && q_data.last) begin
      exact_alive_nxt = '1;
      open_alive_nxt  = '1;
      key_count_nxt   = '0;
      for (int i = 0; i < TAIL_DEPTH; i++) tail_nxt[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exact_alive_r <= '1;
      open_alive_r  <= '1;
      key_count_r   <= '0;
      for (int i = 0; i < TAIL_DEPTH; i++) tail_r[i] <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      exact_alive_r <= exact_alive_nxt;
      open_alive_r  <= open_alive_nxt;
      key_count_r   <= key_count_nxt;
      tail_r        <= tail_nxt;
      if (pop && q_data.last)  out_valid_r <= 1'b1;
      else if (out_word.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) begin
      found_r  <= found;
      length_r <= count_upd[LEN_W-1:0];
    end
  end

  assign out_word.valid         = out_valid_r;
  assign out_word.phrase_found  = found_r;
  assign out_word.folded_length = length_r;

endmodule

// ===== hw/rtl/folded_phrase_detector_core.sv =====
// top level of the folded phrase detector: front, queue and back joined up
// depends on fpd_pkg, fpd_if, fpd_front, fpd_queue and fpd_back
//
//   channel   | dir | word contents                  | handshake
//   in_word   | in  | text_byte[7:0], line_end       | valid/ready
//   out_word  | out | phrase_found, folded_length[5:0] | valid/ready
//
// one byte a cycle while the queue has room; folded in the cycle it is taken
// a line_end step passes the queue, then its verdict is registered and shown
// the back updates match vectors and tail window one step per cycle when queued
// a held verdict stalls only line_end steps; the 2-deep queue absorbs the rest
// synchronous active-low reset returns all match state to its empty line
module folded_phrase_detector_core (
  input  logic      clk,
  input  logic      rst_n,
  fpd_in_if.sink    in_word,
  fpd_out_if.source out_word
);
  import fpd_pkg::*;

  logic   q_wr, q_full, q_valid, q_rd;
  entry_t q_wdata, q_rdata;

  fpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  fpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_wdata),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_rdata),
    .rd_en    (q_rd)
  );

  fpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .out_word (out_word)
  );

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for folded_phrase_detector_core: utf-8 lines in, one verdict word per line
// depends on fpd_pkg and the fpd_in_if / fpd_out_if channel interfaces
// a scoreboard class folds every accepted byte and compares each verdict in order
module tb_top;
  import fpd_pkg::*;

  localparam int N_EXACT       = 14;
  localparam int N_OPENING     = 4;
  localparam int N_ENDING      = 2;
  localparam int TAIL_LEN      = 14;
  localparam int KEY_CAP       = 63;
  localparam int PHASE_BYTES   = 400;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_IDLE = 4000;
  localparam int SEND_IDLE [4] = '{0, 47, 0, 27};
  localparam int RECV_STALL[4] = '{0, 0, 47, 27};

  typedef struct packed {
    bit             found;
    bit [LEN_W-1:0] len;
  } verdict_t;

  class verdict_board;
    string         exact_txt[N_EXACT];
    string         opening_txt[N_OPENING];
    string         ending_txt[N_ENDING];
    bit            lead_pending;
    bit [7:0]      lead_val;
    bit            skipping;
    bit [N_EXACT-1:0]   exact_alive;
    bit [N_OPENING-1:0] opening_alive;
    int            key_count;
    bit [6:0]      tail[TAIL_LEN];
    verdict_t      pending_verdicts[$];
    int            failures;
    int            checked;
    int            hits;
    int            saturated;

    function new();
      string al, am;
      al = "altyazimk";
      am = "amara";
      exact_txt[0]  = al;
      exact_txt[1]  = {al, "com"};
      exact_txt[2]  = "altyaziauthor";
      exact_txt[3]  = "aboneolmayiunutmayin";
      exact_txt[4]  = "kanalimaaboneolmayiunutmayin";
      exact_txt[5]  = "videoyubegendiyseniz";
      exact_txt[6]  = "bubolumunbetimlemesi";
      exact_txt[7]  = {"subtitlesbythe", am, "org", "community"};
      exact_txt[8]  = {"subtitlesby", am, "org"};
      exact_txt[9]  = {am, "org"};
      exact_txt[10] = "thanksforwatching";
      exact_txt[11] = "thankyouforwatching";
      exact_txt[12] = "pleasesubscribe";
      exact_txt[13] = "subscribetomychannel";
      opening_txt[0] = "budizininbetimlemesi";
      opening_txt[1] = "bufilminbetimlemesi";
      opening_txt[2] = "buprograminbetimlemesi";
      opening_txt[3] = "bubolumunbetimlemesi";
      ending_txt[0]  = "yaptirilmistir";
      ending_txt[1]  = "yapilmistir";
      failures = 0;
      checked = 0;
      hits = 0;
      saturated = 0;
      clear_line();
    endfunction

    function void clear_line();
      lead_pending = 0;
      lead_val = '0;
      skipping = 0;
      exact_alive = '1;
      opening_alive = '1;
      key_count = 0;
      foreach (tail[i]) tail[i] = '0;
    endfunction

    function bit [7:0] pair_letter(bit [7:0] a, bit [7:0] b);
      case ({a, b})
        16'hC3A7, 16'hC387: return "c";
        16'hC49F, 16'hC49E: return "g";
        16'hC4B1, 16'hC4B0: return "i";
        16'hC3B6, 16'hC396: return "o";
        16'hC59F, 16'hC59E: return "s";
        16'hC3BC, 16'hC39C: return "u";
        default:            return 8'h00;
      endcase
    endfunction

    function void push_char(bit [7:0] ch);
      for (int k = 0; k < N_EXACT; k++) begin
        if (key_count >= exact_txt[k].len() || exact_txt[k][key_count] != ch)
          exact_alive[k] = 0;
      end
      for (int k = 0; k < N_OPENING; k++) begin
        if (key_count < opening_txt[k].len() && opening_txt[k][key_count] != ch)
          opening_alive[k] = 0;
      end
      for (int i = TAIL_LEN - 1; i > 0; i--) tail[i] = tail[i-1];
      tail[0] = ch[6:0];
      if (key_count < KEY_CAP) key_count++;
    endfunction

    function void fold_fresh(bit [7:0] b);
      if (b < 8'h80) begin
        if (b >= "A" && b <= "Z") push_char(b + 8'h20);
        else if ((b >= "a" && b <= "z") || (b >= "0" && b <= "9")) push_char(b);
      end else begin
        lead_pending = 1;
        lead_val = b;
      end
    endfunction

    function bit tail_ends_with(int j);
      int       n;
      bit [7:0] c;
      n = ending_txt[j].len();
      if (n > TAIL_LEN || key_count < n) return 0;
      for (int i = 0; i < n; i++) begin
        c = ending_txt[j][n-1-i];
        if (tail[i] != c[6:0]) return 0;
      end
      return 1;
    endfunction

    function bit judge();
      int olen;
      if (key_count == 0) return 0;
      for (int k = 0; k < N_EXACT; k++) begin
        if (exact_alive[k] && key_count == exact_txt[k].len()) return 1;
      end
      for (int k = 0; k < N_OPENING; k++) begin
        olen = opening_txt[k].len();
        if (opening_alive[k] && key_count >= olen) begin
          for (int j = 0; j < N_ENDING; j++) begin
            if (key_count >= olen + ending_txt[j].len() && tail_ends_with(j)) return 1;
          end
        end
      end
      return 0;
    endfunction

    function void fold_byte(bit [7:0] b, bit fin);
      bit       cont;
      bit [7:0] m;
      verdict_t w;
      cont = (b[7:6] == 2'b10);
      if (lead_pending) begin
        m = pair_letter(lead_val, b);
        lead_pending = 0;
        lead_val = '0;
        if (m != 0) push_char(m);
        else if (cont) skipping = 1;
        else fold_fresh(b);
      end else if (skipping) begin
        if (!cont) begin
          skipping = 0;
          fold_fresh(b);
        end
      end else begin
        fold_fresh(b);
      end
      if (fin) begin
        w.found = judge();
        w.len = LEN_W'(key_count);
        hits += w.found;
        if (key_count == KEY_CAP) saturated++;
        pending_verdicts.push_back(w);
        clear_line();
      end
    endfunction

    function void check_verdict(logic found, logic [LEN_W-1:0] len);
      verdict_t w;
      if (pending_verdicts.size() == 0) begin
        $error("verdict word with none outstanding: phrase_found %0d folded_length %0d",
               found, len);
        failures++;
        return;
      end
      w = pending_verdicts.pop_front();
      checked++;
      if (found !== w.found) begin
        $error("phrase_found expected %0d actual %0d", w.found, found);
        failures++;
      end
      if (len !== w.len) begin
        $error("folded_length expected %0d actual %0d", w.len, len);
        failures++;
      end
    endfunction
  endclass

  bit clk;
  bit rst_n;
  fpd_in_if  in_ch();
  fpd_out_if out_ch();

  folded_phrase_detector_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  verdict_board board;
  bit [7:0]     line_buf[$];
  string        alnum_chars = "abcdefghijklmnopqrstuvwxyz0123456789";
  int           send_idle;
  int           recv_stall;
  int           hold_cycles;
  int           items_sent;
  int           lines_sent;

  initial clk = 0;
  always #2 clk = ~clk;

  // receiver side: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_verdict(out_ch.phrase_found, out_ch.folded_length);
  end

  task automatic put_byte(input bit [7:0] b, input bit fin);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.text_byte = b;
    in_ch.line_end = fin;
    do @(posedge clk); while (!in_ch.ready);
    board.fold_byte(b, fin);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) put_byte(line_buf[i], i == line_buf.size() - 1);
    lines_sent++;
    line_buf.delete();
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (board.pending_verdicts.size() != 0) @(negedge clk);
  endtask

  function automatic string rand_alnum();
    int i;
    i = $urandom_range(35);
    return alnum_chars.substr(i, i);
  endfunction

  function automatic string filler(int n);
    string s;
    s = "";
    repeat (n) s = {s, rand_alnum()};
    return s;
  endfunction

  function automatic bit [15:0] turkish_form(bit [7:0] c, bit cap);
    case (c)
      "c":     return cap ? 16'hC387 : 16'hC3A7;
      "g":     return cap ? 16'hC49E : 16'hC49F;
      "i":     return cap ? 16'hC4B0 : 16'hC4B1;
      "o":     return cap ? 16'hC396 : 16'hC3B6;
      "s":     return cap ? 16'hC59E : 16'hC59F;
      "u":     return cap ? 16'hC39C : 16'hC3BC;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic add_junk();
    case ($urandom_range(4))
      0: line_buf.push_back(8'h20 + 8'($urandom_range(15)));
      1: begin
        line_buf.push_back(8'hE2);
        repeat (2) line_buf.push_back(8'h80 | 8'($urandom_range(63)));
      end
      2: begin
        line_buf.push_back(8'hF0 + 8'($urandom_range(4)));
        repeat (3) line_buf.push_back(8'h80 | 8'($urandom_range(63)));
      end
      3: begin
        line_buf.push_back(8'hC3);
        line_buf.push_back(8'hA9);
      end
      default: line_buf.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic add_text(input string s, input int noise);
    bit [7:0]  c;
    bit [15:0] tk;
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(99) < noise) add_junk();
      c = s[i];
      tk = turkish_form(c, 1'($urandom_range(1)));
      if (tk != 0 && $urandom_range(3) == 0) begin
        line_buf.push_back(tk[15:8]);
        line_buf.push_back(tk[7:0]);
      end else if (c >= "a" && c <= "z" && $urandom_range(2) == 0) begin
        line_buf.push_back(c - 8'h20);
      end else begin
        line_buf.push_back(c);
      end
    end
    if ($urandom_range(99) < noise) add_junk();
  endtask

  task automatic build_line(input int kind);
    string s;
    int    p;
    case (kind)
      0, 1, 2: add_text(board.exact_txt[$urandom_range(N_EXACT-1)], 10);
      3, 4: begin
        s = {board.opening_txt[$urandom_range(N_OPENING-1)], filler($urandom_range(6)),
             board.ending_txt[$urandom_range(N_ENDING-1)]};
        add_text(s, 10);
      end
      5: begin
        // near miss: one letter changed or dropped, or one character added
        s = board.exact_txt[$urandom_range(N_EXACT-1)];
        p = $urandom_range(s.len() - 1);
        case ($urandom_range(2))
          0:       s[p] = (s[p] == "z") ? "a" : s[p] + 8'd1;
          1:       s = {s.substr(0, p - 1), s.substr(p + 1, s.len() - 1)};
          default: s = {s, rand_alnum()};
        endcase
        add_text(s, 10);
      end
      6: begin
        // long keys, some of which saturate the length count
        s = filler($urandom_range(50, 80));
        if ($urandom_range(1))
          s = {board.opening_txt[$urandom_range(N_OPENING-1)], s,
               board.ending_txt[$urandom_range(N_ENDING-1)]};
        add_text(s, 3);
      end
      7: repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(255)));
      8: add_text(filler($urandom_range(1, 4)), 20);
      default: begin
        case ($urandom_range(2))
          0:       s = board.opening_txt[$urandom_range(N_OPENING-1)];
          1:       s = board.ending_txt[$urandom_range(N_ENDING-1)];
          default: begin
            s = board.exact_txt[$urandom_range(N_EXACT-1)];
            s = s.substr(0, $urandom_range(s.len() - 2));
          end
        endcase
        add_text(s, 10);
      end
    endcase
  endtask

  // no-progress watchdog over both channels
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < WATCHDOG_IDLE) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int goal;
    board = new();
    in_ch.valid = 1'b0;
    in_ch.text_byte = '0;
    in_ch.line_end = 1'b0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    hold_cycles = 0;
    items_sent = 0;
    lines_sent = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // empty key, then a lead byte left pending at the end of the line
    line_buf = '{8'h00};
    send_line();
    line_buf = '{8'hFF};
    send_line();
    // mapped pair, lone continuation, skipped sequence, unmapped pair refolded
    line_buf = '{8'hC3, 8'hA7, 8'h80, 8'h41, 8'hE2, 8'h82, 8'hAC, 8'h5A, 8'hC4, 8'h7A};
    send_line();
    line_buf = '{8'hC4, 8'hB0, 8'h30, 8'h39, 8'hC5, 8'h9E};
    send_line();
    // ascii neighbours of the letter and digit ranges
    line_buf = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h7F};
    send_line();

    // receiver holds off while short lines keep coming, so the input backs up
    hold_cycles = HOLD_CYCLES;
    repeat (10) begin
      build_line(8);
      send_line();
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = SEND_IDLE[ph];
      recv_stall = RECV_STALL[ph];
      goal = items_sent + PHASE_BYTES;
      while (items_sent < goal) begin
        build_line($urandom_range(9));
        send_line();
      end
    end
    drain();
    repeat (16) @(negedge clk);

    $display("sent %0d bytes in %0d lines under four idle/stall mixes and one long hold-off",
             items_sent, lines_sent);
    $display("compared %0d verdicts: %0d phrase hits, %0d saturated keys",
             board.checked, board.hits, board.saturated);
    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== folded_phrase_detector_core.f =====
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_if.sv
hw/rtl/fpd_front.sv
hw/rtl/fpd_queue.sv
hw/rtl/fpd_back.sv
hw/rtl/folded_phrase_detector_core.sv
bench/tb_top.sv
